// ===== sv/jsfe_pkg.sv =====
// jsfe_pkg: types, constants and helper functions of the JSON string field extractor.
// Used by json_string_field_extractor; depends on nothing else.
`default_nettype none

package jsfe_pkg;

    // Key storage and match window
    localparam int KEY_MAX    = 32;
    localparam int KEY_CHARS  = 32;           // characters held by the four key registers
    localparam int WIN_LEN    = KEY_MAX + 2;  // quote, key, quote
    localparam int KLEN_W     = 6;
    localparam int WIN_IDX_W  = $clog2(WIN_LEN);

    // Result queue
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W   = RQ_PTR_W + 1;

    // Register file
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam logic [2:0] REG_KEY_0_7   = 3'd0;
    localparam logic [2:0] REG_KEY_8_15  = 3'd1;
    localparam logic [2:0] REG_KEY_16_23 = 3'd2;
    localparam logic [2:0] REG_KEY_24_31 = 3'd3;
    localparam logic [2:0] REG_KEY_LEN   = 3'd4;
    localparam logic [2:0] REG_OUT_CAP   = 3'd5;
    localparam logic [15:0] OUT_CAP_RESET = 16'd256;

    // Result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [15:0] PRINT_LO = 16'h0020;
    localparam logic [15:0] PRINT_HI = 16'h007e;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_PRECOLON,
        PH_POSTCOLON,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        DM_NORMAL,
        DM_ESCAPE,
        DM_HEX0,
        DM_HEX1,
        DM_HEX2,
        DM_HEX3
    } dmode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       run_end;
    } result_t;

    // Single-character escapes; anything else passes through
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h6e:   r = 8'h0a;  // n
                8'h72:   r = 8'h0d;  // r
                8'h74:   r = 8'h09;  // t
                8'h62:   r = 8'h08;  // b
                8'h66:   r = 8'h0c;  // f
                default: r = c;
            endcase
            return r;
        end
    endfunction

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    // Printable code maps to itself, else '?'
    function automatic logic [7:0] code_char(input logic [15:0] code);
        logic [7:0] r;
        begin
            if (code >= PRINT_LO && code <= PRINT_HI) begin
                r = code[7:0];
            end else begin
                r = CH_QMARK;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/json_string_field_extractor.sv =====
// json_string_field_extractor: finds a quoted key in a JSON body and streams its unescaped value.
// Depends on jsfe_pkg (types, constants, escape and hex helpers).
//
// Usage:
//   Body bytes enter on the s_ channel (s_body_byte, s_body_last), one word per handshake.
//   Results leave on the m_ channel: value characters (m_item_kind 0), then one finish
//   (1) or error (2) word carrying m_run_end. On an error the receiver drops the
//   characters already taken for that body. State returns to the search phase after
//   every byte that carries s_body_last.
//   Key, key length and output capacity are written over the APB port (64-bit registers
//   at 8*i); pready is always high. Write them only while no body is in flight.
// Timing:
//   Each accepted byte is processed in the cycle of acceptance; its results are written
//   into a 4-entry result queue and show on m_ from its head. One byte per cycle is taken
//   while the queue has room for two words, so sustained rate is one byte per cycle
//   whenever each byte yields at most one word and m_ready stays high. A byte that
//   yields a character and a finish/error word puts two words on m_.
// Reset (aresetn low, synchronous) empties the queue, clears the key registers, sets
//   the capacity to 256 and restarts the search. When m_ready is low the queue fills
//   and s_ready drops once fewer than two entries are free.
`default_nettype none

module json_string_field_extractor import jsfe_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // byte input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_body_byte,
    input  wire logic              s_body_last,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_item_kind,
    output logic [7:0]             m_value_char,
    output logic                   m_run_end,
    // APB register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // Registers
    logic [DATA_W-1:0]   key0_reg, key1_reg, key2_reg, key3_reg;
    logic [KLEN_W-1:0]   key_len_cfg_reg;
    logic [15:0]         out_cap_reg;

    // Scan state
    phase_t              phase_reg, phase_next;
    dmode_t              dmode_reg, dmode_next;
    logic                esc_pend_reg, esc_pend_next;
    logic [15:0]         hex_code_reg, hex_code_next;
    logic                hex_stop_reg, hex_stop_next;
    logic [15:0]         emitted_reg, emitted_next;
    logic [WIN_LEN-1:0]  prefix_reg, prefix_next;

    // Result queue
    result_t             rq_mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_head_reg, rq_tail_reg;
    logic [RQ_CNT_W-1:0] rq_count_reg;

    logic                take, pop;
    logic [7:0]          c;
    logic [8*KEY_CHARS-1:0] key_flat;
    logic [KLEN_W-1:0]   key_len_clamp, key_len;
    logic [WIN_LEN-1:0]  pat_eq;
    logic [WIN_IDX_W-1:0] match_idx;
    logic                key_hit;
    logic [4:0]          hex_d;
    logic [15:0]         hex_code_upd;
    logic                hex_upd_stop;
    logic [15:0]         cap_m1;
    logic                can_emit;
    logic                is_blank;

    // Result decisions for the current byte
    logic                char_want, char_emit, finish, fail, term;
    logic [7:0]          char_val;
    result_t             term_word;
    logic [RQ_PTR_W-1:0] wr_idx_term;

    assign take   = s_valid & s_ready;
    assign pop    = m_valid & m_ready;
    assign c      = s_body_byte;
    assign pready = 1'b1;

    // ---------------- APB registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg        <= '0;
            key1_reg        <= '0;
            key2_reg        <= '0;
            key3_reg        <= '0;
            key_len_cfg_reg <= '0;
            out_cap_reg     <= OUT_CAP_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_KEY_0_7:   key0_reg        <= pwdata;
                REG_KEY_8_15:  key1_reg        <= pwdata;
                REG_KEY_16_23: key2_reg        <= pwdata;
                REG_KEY_24_31: key3_reg        <= pwdata;
                REG_KEY_LEN:   key_len_cfg_reg <= pwdata[KLEN_W-1:0];
                REG_OUT_CAP:   out_cap_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[5:3])
            REG_KEY_0_7:   prdata = key0_reg;
            REG_KEY_8_15:  prdata = key1_reg;
            REG_KEY_16_23: prdata = key2_reg;
            REG_KEY_24_31: prdata = key3_reg;
            REG_KEY_LEN:   prdata = {{(DATA_W-KLEN_W){1'b0}}, key_len_cfg_reg};
            REG_OUT_CAP:   prdata = {{(DATA_W-16){1'b0}}, out_cap_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- key length in use ----------------
    assign key_flat = {key3_reg, key2_reg, key1_reg, key0_reg};

    always_comb begin
        if (key_len_cfg_reg > KLEN_W'(KEY_MAX)) begin
            key_len_clamp = KLEN_W'(KEY_MAX);
        end else begin
            key_len_clamp = key_len_cfg_reg;
        end
    end

    // Key stops at its first zero character
    always_comb begin
        key_len = key_len_clamp;
        for (int k = KEY_CHARS - 1; k >= 0; k--) begin
            if (key_flat[8*k +: 8] == CH_NUL && KLEN_W'(k) < key_len_clamp) begin
                key_len = KLEN_W'(k);
            end
        end
    end

    // ---------------- key search: prefix match bits ----------------
    // pattern byte i is a quote at both ends, key character i-1 between
    always_comb begin
        pat_eq[0] = (c == CH_QUOTE);
        for (int i = 1; i < WIN_LEN; i++) begin
            if (KLEN_W'(i - 1) == key_len || i - 1 >= KEY_CHARS) begin
                pat_eq[i] = (c == CH_QUOTE);
            end else begin
                pat_eq[i] = (c == key_flat[8*((i-1) % KEY_CHARS) +: 8]);
            end
        end
    end

    // bit i set: last i+1 bytes equal the first i+1 pattern bytes
    assign prefix_next = {prefix_reg[WIN_LEN-2:0], 1'b1} & pat_eq;
    assign match_idx   = WIN_IDX_W'(key_len + KLEN_W'(1));
    assign key_hit     = prefix_next[match_idx];

    // ---------------- value decode helpers ----------------
    assign hex_d        = hex_digit(c);
    assign hex_upd_stop = hex_stop_reg | ~hex_d[4];
    assign hex_code_upd = hex_upd_stop ? hex_code_reg : {hex_code_reg[11:0], hex_d[3:0]};

    assign cap_m1   = (out_cap_reg == 16'd0) ? 16'd0 : out_cap_reg - 16'd1;
    assign can_emit = emitted_reg < cap_m1;
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB);

    // ---------------- result decisions ----------------
    always_comb begin
        char_want = 1'b0;
        char_val  = CH_NUL;
        finish    = 1'b0;
        fail      = 1'b0;
        case (phase_reg)
            PH_SEARCH: begin
                fail = (c == CH_NUL);
            end
            PH_PRECOLON: begin
                fail = !is_blank && (c != CH_COLON);
            end
            PH_POSTCOLON: begin
                fail = !is_blank && (c != CH_QUOTE);
            end
            PH_VALUE: begin
                if (c == CH_NUL) begin
                    fail = 1'b1;
                end else if (!esc_pend_reg && c == CH_QUOTE) begin
                    // closing quote flushes a short unicode escape
                    finish    = 1'b1;
                    char_want = dmode_reg inside {DM_HEX0, DM_HEX1, DM_HEX2, DM_HEX3};
                    char_val  = code_char(hex_code_reg);
                end else begin
                    case (dmode_reg)
                        DM_NORMAL: begin
                            char_want = (c != CH_BSLASH);
                            char_val  = c;
                        end
                        DM_ESCAPE: begin
                            char_want = (c != CH_U);
                            char_val  = esc_map(c);
                        end
                        DM_HEX3: begin
                            char_want = 1'b1;
                            char_val  = code_char(hex_code_upd);
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign char_emit = char_want & can_emit;
    // finish word, or error on failure or on the last byte of a body not yet finished
    assign term      = finish | fail | (s_body_last & (phase_reg != PH_DONE));

    always_comb begin
        term_word.ch      = CH_NUL;
        term_word.run_end = 1'b1;
        term_word.kind    = finish ? KIND_FINISH : KIND_ERROR;
    end

    // ---------------- next scan state ----------------
    always_comb begin
        phase_next    = phase_reg;
        dmode_next    = dmode_reg;
        esc_pend_next = esc_pend_reg;
        hex_code_next = hex_code_reg;
        hex_stop_next = hex_stop_reg;
        emitted_next  = emitted_reg + (char_emit ? 16'd1 : 16'd0);
        case (phase_reg)
            PH_SEARCH: begin
                if (c != CH_NUL && key_hit) begin
                    phase_next = PH_PRECOLON;
                end
            end
            PH_PRECOLON: begin
                if (c == CH_COLON) begin
                    phase_next = PH_POSTCOLON;
                end
            end
            PH_POSTCOLON: begin
                if (c == CH_QUOTE) begin
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (c != CH_NUL && !(!esc_pend_reg && c == CH_QUOTE)) begin
                    esc_pend_next = esc_pend_reg ? 1'b0 : (c == CH_BSLASH);
                    case (dmode_reg)
                        DM_NORMAL: begin
                            if (c == CH_BSLASH) begin
                                dmode_next = DM_ESCAPE;
                            end
                        end
                        DM_ESCAPE: begin
                            if (c == CH_U) begin
                                dmode_next    = DM_HEX0;
                                hex_code_next = 16'd0;
                                hex_stop_next = 1'b0;
                            end else begin
                                dmode_next = DM_NORMAL;
                            end
                        end
                        DM_HEX0: begin
                            hex_code_next = hex_code_upd;
                            hex_stop_next = hex_upd_stop;
                            dmode_next    = DM_HEX1;
                        end
                        DM_HEX1: begin
                            hex_code_next = hex_code_upd;
                            hex_stop_next = hex_upd_stop;
                            dmode_next    = DM_HEX2;
                        end
                        DM_HEX2: begin
                            hex_code_next = hex_code_upd;
                            hex_stop_next = hex_upd_stop;
                            dmode_next    = DM_HEX3;
                        end
                        DM_HEX3: begin
                            hex_code_next = hex_code_upd;
                            hex_stop_next = hex_upd_stop;
                            dmode_next    = DM_NORMAL;
                        end
                        default: dmode_next = DM_NORMAL;
                    endcase
                end
            end
            default: ;
        endcase
        if (term) begin
            phase_next = PH_DONE;
        end
    end

    // Scan state registers; the last byte of a body restarts the search
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEARCH;
            dmode_reg    <= DM_NORMAL;
            esc_pend_reg <= 1'b0;
            hex_code_reg <= 16'd0;
            hex_stop_reg <= 1'b0;
            emitted_reg  <= 16'd0;
            prefix_reg   <= '0;
        end else if (take) begin
            if (s_body_last) begin
                phase_reg    <= PH_SEARCH;
                dmode_reg    <= DM_NORMAL;
                esc_pend_reg <= 1'b0;
                hex_code_reg <= 16'd0;
                hex_stop_reg <= 1'b0;
                emitted_reg  <= 16'd0;
                prefix_reg   <= '0;
            end else begin
                phase_reg    <= phase_next;
                dmode_reg    <= dmode_next;
                esc_pend_reg <= esc_pend_next;
                hex_code_reg <= hex_code_next;
                hex_stop_reg <= hex_stop_next;
                emitted_reg  <= emitted_next;
                if (phase_reg == PH_SEARCH) begin
                    prefix_reg <= prefix_next;
                end
            end
        end
    end

    // ---------------- result queue ----------------
    assign wr_idx_term = rq_tail_reg + (char_emit ? RQ_PTR_W'(1) : RQ_PTR_W'(0));
    assign s_ready     = rq_count_reg <= RQ_CNT_W'(RQ_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (take && char_emit) begin
            rq_mem_reg[rq_tail_reg] <= '{kind: KIND_CHAR, ch: char_val, run_end: 1'b0};
        end
        if (take && term) begin
            rq_mem_reg[wr_idx_term] <= term_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rq_head_reg  <= '0;
            rq_tail_reg  <= '0;
            rq_count_reg <= '0;
        end else begin
            if (pop) begin
                rq_head_reg <= rq_head_reg + RQ_PTR_W'(1);
            end
            if (take) begin
                rq_tail_reg <= rq_tail_reg + RQ_PTR_W'(char_emit) + RQ_PTR_W'(term);
            end
            rq_count_reg <= rq_count_reg
                          + (take ? RQ_CNT_W'(char_emit) + RQ_CNT_W'(term) : RQ_CNT_W'(0))
                          - (pop ? RQ_CNT_W'(1) : RQ_CNT_W'(0));
        end
    end

    // Head of the queue drives the output word
    assign m_valid      = rq_count_reg != '0;
    assign m_item_kind  = rq_mem_reg[rq_head_reg].kind;
    assign m_value_char = rq_mem_reg[rq_head_reg].ch;
    assign m_run_end    = rq_mem_reg[rq_head_reg].run_end;

endmodule

`default_nettype wire
